FILE: design/lpht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

    // Field widths of the stream words and the configuration register.
    localparam int KEY_W        = 31;
    localparam int STATUS_W     = 3;
    localparam int SLOT_W       = 10;
    localparam int PROBE_W      = 11;
    localparam int OCC_W        = 11;
    localparam int CFG_SIZE_W   = 11;
    localparam int S_TDATA_W    = 32;
    localparam int M_TDATA_W    = 40;
    localparam int M_FIELDS_W   = STATUS_W + SLOT_W + PROBE_W + OCC_W;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;

    // Register map: word index of each configuration register.
    localparam logic REG_TABLE_SIZE = 1'b0;

    localparam logic [CFG_SIZE_W-1:0] TABLE_SIZE_RST = 11'd1024;

    // Operation selector carried on the input tuser bit.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_FULL     = 3'd2,
        ST_FOUND    = 3'd3,
        ST_MISSING  = 3'd4
    } lpht_status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic accept;
        logic div_step;
        logic probe_start;
        logic probe_adv;
        logic finish;
        logic out_load;
    } lpht_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic key_zero;
        logic div_last;
        logic term;
    } lpht_stat_t;

endpackage

`default_nettype wire

FILE: design/lpht_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module lpht_datapath
    import lpht_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire lpht_cmd_t             cmd,
    output lpht_stat_t                 stat,
    input  wire logic                  in_kind,
    input  wire logic [KEY_W-1:0]      in_key,
    input  wire logic [CFG_SIZE_W-1:0] table_size,
    output logic [M_TDATA_W-1:0]       out_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = (SW > CFG_SIZE_W) ? SW : CFG_SIZE_W;
    localparam int DVD_W = KEY_W + 1;
    localparam int DIV_STEPS = DVD_W / 2;
    localparam int DCW = $clog2(DIV_STEPS);

    // Slot store and its registered read port.
    logic [KEY_W-1:0]  mem [TABLE_DEPTH];
    logic [KEY_W-1:0]  mem_q_reg;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [KEY_W-1:0]  wr_data;
    logic              wr_en;

    logic [AW-1:0]     clr_addr_reg;
    logic              kind_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [SW-1:0]     size_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [SW-1:0]     rem_reg;
    logic [SW-1:0]     rem_next;
    logic [DCW-1:0]    div_cnt_reg;
    logic [AW-1:0]     pos_reg;
    logic [AW-1:0]     pos_next;
    logic [AW-1:0]     pos_wrap;
    logic [SW-1:0]     cnt_reg;
    logic [SW-1:0]     cnt_inc;
    logic [SW-1:0]     filled_reg;
    lpht_status_t      res_status_reg;
    logic [AW-1:0]     res_slot_reg;
    logic [SW-1:0]     res_cnt_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic [XW-1:0]     size_ext;
    logic [SW-1:0]     size_eff;
    logic [SW:0]       step1_w;
    logic [SW-1:0]     step1;
    logic [SW:0]       step2_w;
    logic [AW:0]       pos_inc;
    logic              v_zero;
    logic              v_match;
    logic              scan_last;
    lpht_status_t      fin_status;
    logic [AW-1:0]     fin_slot;
    logic [SW-1:0]     fin_cnt;
    logic              fin_write;

    // A size of zero acts as one slot; a size above the store acts as the whole store.
    always_comb begin
        size_ext = XW'(table_size);
        if (size_ext == '0) begin
            size_eff = SW'(1);
        end else if (size_ext > XW'(TABLE_DEPTH)) begin
            size_eff = SW'(TABLE_DEPTH);
        end else begin
            size_eff = SW'(size_ext);
        end
    end

    // Restoring remainder, two dividend bits per cycle.
    always_comb begin
        step1_w = {rem_reg, dvd_reg[DVD_W-1]};
        step1   = (step1_w >= {1'b0, size_reg}) ? SW'(step1_w - {1'b0, size_reg})
                                                 : SW'(step1_w);
        step2_w = {step1, dvd_reg[DVD_W-2]};
        rem_next = (step2_w >= {1'b0, size_reg}) ? SW'(step2_w - {1'b0, size_reg})
                                                  : SW'(step2_w);
    end

    // Next probe position wraps to slot zero at the end of the active table.
    always_comb begin
        pos_inc  = {1'b0, pos_reg} + (AW + 1)'(1);
        pos_wrap = (pos_inc >= (AW + 1)'(size_reg)) ? '0 : pos_inc[AW-1:0];
        if (cmd.probe_start) begin
            pos_next = rem_next[AW-1:0];
        end else if (cmd.probe_adv) begin
            pos_next = pos_wrap;
        end else begin
            pos_next = pos_reg;
        end
    end

    // Outcome of the slot whose word sits in the read register.
    always_comb begin
        v_zero    = (mem_q_reg == '0);
        v_match   = (mem_q_reg == key_reg);
        cnt_inc   = cnt_reg + SW'(1);
        scan_last = (cnt_inc == size_reg);
        fin_write = 1'b0;
        fin_slot  = '0;
        if (kind_reg == KIND_INSERT) begin
            if (v_zero) begin
                fin_status = ST_INSERTED;
                fin_slot   = pos_reg;
                fin_cnt    = cnt_reg;
                fin_write  = 1'b1;
            end else if (v_match) begin
                fin_status = ST_PRESENT;
                fin_slot   = pos_reg;
                fin_cnt    = cnt_reg;
            end else begin
                fin_status = ST_FULL;
                fin_cnt    = cnt_inc;
            end
        end else begin
            if (v_match) begin
                fin_status = ST_FOUND;
                fin_slot   = pos_reg;
                fin_cnt    = cnt_inc;
            end else if (v_zero) begin
                fin_status = ST_MISSING;
                fin_cnt    = cnt_reg;
            end else begin
                fin_status = ST_MISSING;
                fin_cnt    = cnt_inc;
            end
        end
    end

    assign stat.clr_last = (clr_addr_reg == AW'(TABLE_DEPTH - 1));
    assign stat.key_zero = (in_key == '0);
    assign stat.div_last = (div_cnt_reg == DCW'(DIV_STEPS - 1));
    assign stat.term     = v_zero || v_match || scan_last;

    // Memory write port serves the clearing pass and inserts.
    assign rd_addr = pos_next;
    assign wr_en   = cmd.clr_step || (cmd.finish && fin_write);
    assign wr_addr = cmd.clr_step ? clr_addr_reg : pos_reg;
    assign wr_data = cmd.clr_step ? '0 : key_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        mem_q_reg <= mem[rd_addr];
    end

    // Control counters: clearing address and occupied count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            filled_reg   <= '0;
        end else begin
            if (cmd.clr_step) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.finish && fin_write) begin
                filled_reg <= filled_reg + SW'(1);
            end
        end
    end

    // Operation registers, divider, probe walk and result words.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            kind_reg       <= in_kind;
            key_reg        <= in_key;
            size_reg       <= size_eff;
            dvd_reg        <= {1'b0, in_key};
            rem_reg        <= '0;
            div_cnt_reg    <= '0;
            res_status_reg <= (in_kind == KIND_SEARCH) ? ST_MISSING : ST_PRESENT;
            res_slot_reg   <= '0;
            res_cnt_reg    <= '0;
        end
        if (cmd.div_step) begin
            dvd_reg     <= {dvd_reg[DVD_W-3:0], 2'b00};
            rem_reg     <= rem_next;
            div_cnt_reg <= div_cnt_reg + DCW'(1);
        end
        pos_reg <= pos_next;
        if (cmd.probe_start) begin
            cnt_reg <= '0;
        end else if (cmd.probe_adv) begin
            cnt_reg <= cnt_inc;
        end
        if (cmd.finish) begin
            res_status_reg <= fin_status;
            res_slot_reg   <= fin_slot;
            res_cnt_reg    <= fin_cnt;
        end
        if (cmd.out_load) begin
            out_data_reg <= {(M_TDATA_W - M_FIELDS_W)'(0), OCC_W'(filled_reg),
                             PROBE_W'(res_cnt_reg), SLOT_W'(res_slot_reg),
                             res_status_reg};
        end
    end

    assign out_data = out_data_reg;

endmodule

`default_nettype wire

FILE: design/lpht_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lpht_ctrl
    import lpht_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    input  wire lpht_stat_t stat,
    output lpht_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_READ,
        S_PROBE,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    // Sequencing of one operation: modulo, first read, probe walk, result.
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = stat.key_zero ? S_DONE : S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    cmd.probe_start = 1'b1;
                    state_next      = S_READ;
                end
            end
            S_READ: begin
                state_next = S_PROBE;
            end
            S_PROBE: begin
                if (stat.term) begin
                    cmd.finish = 1'b1;
                    state_next = S_DONE;
                end else begin
                    cmd.probe_adv = 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // The output word stays valid until the receiver takes it.
    always_comb begin
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

FILE: design/linear_probing_hash_table.sv
// Open-addressing hash table with linear probing over positive 31-bit keys.
// Input stream: s_tdata carries the key, s_tuser selects insert (0) or search (1).
// Result stream: m_tdata carries status, slot index, probe count and the number
// of occupied slots after the operation.
// The APB port holds one register, table_size at byte address 0; a value of zero
// acts as one slot and a value above TABLE_DEPTH acts as TABLE_DEPTH. Write it
// only while no operation is in flight.
// One operation is worked on at a time. From acceptance to its result word an
// item passes through the key modulo the table size (two quotient bits a
// cycle), the first slot read, the probe walk with one slot compared per
// cycle on the single store read port, and the load of the output register.
// A key of zero is answered without touching the store.
// After reset the store is swept to empty, one slot a cycle; s_tready stays
// low meanwhile, but register writes are taken.
// The output register lets the next item be accepted while a result waits;
// if the receiver stalls, the following result is held and no further item
// is accepted until the waiting word is taken.
`timescale 1ns / 1ps
`default_nettype none

module linear_probing_hash_table
    import lpht_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Input stream.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [30:0] key, [31] zero
    input  wire logic                  s_tuser,   // [0] kind
    // Result stream.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // [2:0] status, [12:3] slot_index,
                                                  // [23:13] probe_count,
                                                  // [34:24] occupied_count, [39:35] zero
    // Configuration port.
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    logic [CFG_SIZE_W-1:0] table_size_reg;
    logic                  cfg_wr;
    logic                  reg_sel;
    lpht_cmd_t             cmd;
    lpht_stat_t            stat;

    // Register decode: the word index sits above the byte offset.
    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_ADDR_W-1] == REG_TABLE_SIZE);
    assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
    assign prdata  = reg_sel ? APB_DATA_W'(table_size_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_size_reg <= TABLE_SIZE_RST;
        end else if (cfg_wr) begin
            table_size_reg <= pwdata[CFG_SIZE_W-1:0];
        end
    end

    lpht_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lpht_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_kind    (s_tuser),
        .in_key     (s_tdata[KEY_W-1:0]),
        .table_size (table_size_reg),
        .out_data   (m_tdata)
    );

endmodule

`default_nettype wire

FILE: design/lpht_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lpht_checker
    import lpht_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // A result word waiting for the receiver stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word withdrawn while stalled");

    // A stalled result word does not change.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result word changed while stalled");

    // One operation at a time: after a word is taken the input side closes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on back-to-back cycles");

    // Reset starts the clearing sweep with both streams quiet.
    assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("streams active right after reset");

    // Only defined status codes appear on the result stream.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[STATUS_W-1:0] == ST_INSERTED ||
                      m_tdata[STATUS_W-1:0] == ST_PRESENT  ||
                      m_tdata[STATUS_W-1:0] == ST_FULL     ||
                      m_tdata[STATUS_W-1:0] == ST_FOUND    ||
                      m_tdata[STATUS_W-1:0] == ST_MISSING))
        else $error("undefined status code on result stream");

endmodule

bind linear_probing_hash_table lpht_checker u_lpht_checker (.*);

`default_nettype wire

FILE: tb/tb_linear_probing_hash_table.sv
`timescale 1ns / 1ps

module tb_linear_probing_hash_table;
    import lpht_pkg::*;

    localparam int TABLE_DEPTH   = 1024;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int MAX_GAP       = 5;
    localparam int DRAIN_CYCLES  = 1100;
    localparam int PRINT_CAP     = 30;
    localparam int N_DIRECTED    = 23;

    // One result word, laid out as on m_tdata (status in the lowest bits).
    typedef struct packed {
        logic [OCC_W-1:0]   occupied;
        logic [PROBE_W-1:0] probes;
        logic [SLOT_W-1:0]  slot;
        lpht_status_t       status;
    } outcome_t;

    typedef enum logic [1:0] {
        ROW_INSERT,
        ROW_SEARCH,
        ROW_SIZE
    } row_op_t;

    // One row of the directed table: a key operation or a table_size write.
    typedef struct packed {
        row_op_t          op;
        logic [KEY_W-1:0] arg;
        logic             typed;
        outcome_t         want;
    } step_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;   // [30:0] key, [31] zero
    logic                  s_tuser  = 1'b0; // [0] kind
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;         // [2:0] status, [12:3] slot_index,
                                            // [23:13] probe_count, [34:24] occupied_count
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Shadow copy of the table and its size register.
    logic [KEY_W-1:0]      shadow_slots [TABLE_DEPTH];
    int                    shadow_filled;
    logic [CFG_SIZE_W-1:0] shadow_size = TABLE_SIZE_RST;

    outcome_t              pending_outcomes [$];
    logic [KEY_W-1:0]      stored_keys [$];
    int                    mismatch_count = 0;
    int                    words_seen = 0;
    bit                    calm = 1'b0;

    // Directed table. Rows with typed = 1 carry a hand-written expectation.
    step_t directed_steps [N_DIRECTED] = '{
        '{ROW_SEARCH, 31'd5,          1'b1,
          '{status: ST_MISSING,  slot: 10'd0,    probes: 11'd0, occupied: 11'd0}},
        '{ROW_INSERT, 31'd0,          1'b1,
          '{status: ST_PRESENT,  slot: 10'd0,    probes: 11'd0, occupied: 11'd0}},
        '{ROW_SEARCH, 31'd0,          1'b1,
          '{status: ST_MISSING,  slot: 10'd0,    probes: 11'd0, occupied: 11'd0}},
        '{ROW_INSERT, 31'd1,          1'b1,
          '{status: ST_INSERTED, slot: 10'd1,    probes: 11'd0, occupied: 11'd1}},
        '{ROW_INSERT, 31'h7FFF_FFFF,  1'b1,
          '{status: ST_INSERTED, slot: 10'd1023, probes: 11'd0, occupied: 11'd2}},
        '{ROW_INSERT, 31'd1025,       1'b0, '0},
        '{ROW_SEARCH, 31'd1025,       1'b0, '0},
        '{ROW_INSERT, 31'd1,          1'b0, '0},
        '{ROW_SEARCH, 31'd2049,       1'b0, '0},
        '{ROW_INSERT, 31'd2047,       1'b0, '0},
        '{ROW_SIZE,   31'd0,          1'b0, '0},
        '{ROW_INSERT, 31'd3,          1'b1,
          '{status: ST_FULL,     slot: 10'd0,    probes: 11'd1, occupied: 11'd4}},
        '{ROW_SEARCH, 31'd2047,       1'b0, '0},
        '{ROW_SEARCH, 31'd9,          1'b0, '0},
        '{ROW_INSERT, 31'd0,          1'b1,
          '{status: ST_PRESENT,  slot: 10'd0,    probes: 11'd0, occupied: 11'd4}},
        '{ROW_SIZE,   31'd2047,       1'b0, '0},
        '{ROW_SEARCH, 31'h7FFF_FFFF,  1'b0, '0},
        '{ROW_SIZE,   31'd2,          1'b0, '0},
        '{ROW_INSERT, 31'd4,          1'b0, '0},
        '{ROW_SEARCH, 31'd6,          1'b0, '0},
        '{ROW_SIZE,   31'd1,          1'b0, '0},
        '{ROW_SEARCH, 31'd1,          1'b0, '0},
        '{ROW_SIZE,   31'd1024,       1'b0, '0}
    };

    linear_probing_hash_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #50_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch at word %0d: %s", words_seen, msg);
        mismatch_count++;
    endtask

    // Applies one insert or search to the shadow table and returns its result.
    function automatic outcome_t apply_table_op(input logic kind, input logic [KEY_W-1:0] key);
        outcome_t res;
        int       span;
        int       pos;
        int       probes;
        bit       done;
        span = (shadow_size == 0) ? 1 :
               (int'(shadow_size) > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_size);
        res.slot = '0;
        probes   = 0;
        done     = 1'b0;
        if (key == 0) begin
            res.status = (kind == KIND_SEARCH) ? ST_MISSING : ST_PRESENT;
        end else if (kind == KIND_INSERT) begin
            res.status = ST_FULL;
            pos = int'(key % span);
            for (int i = 0; i < span && !done; i++) begin
                if (shadow_slots[pos] == 0) begin
                    shadow_slots[pos] = key;
                    shadow_filled++;
                    res.status = ST_INSERTED;
                    res.slot   = SLOT_W'(pos);
                    done       = 1'b1;
                end else if (shadow_slots[pos] == key) begin
                    res.status = ST_PRESENT;
                    res.slot   = SLOT_W'(pos);
                    done       = 1'b1;
                end else begin
                    probes++;
                    pos = (pos + 1 >= span) ? 0 : pos + 1;
                end
            end
        end else begin
            res.status = ST_MISSING;
            pos = int'(key % span);
            for (int i = 0; i < span && !done; i++) begin
                if (shadow_slots[pos] == key) begin
                    probes++;
                    res.status = ST_FOUND;
                    res.slot   = SLOT_W'(pos);
                    done       = 1'b1;
                end else if (shadow_slots[pos] == 0) begin
                    done = 1'b1;
                end else begin
                    probes++;
                    pos = (pos + 1 >= span) ? 0 : pos + 1;
                end
            end
        end
        res.probes   = PROBE_W'(probes);
        res.occupied = OCC_W'(shadow_filled);
        return res;
    endfunction

    // Offers one word on the input stream after a random gap and predicts its result.
    task automatic issue_op(input logic kind, input logic [KEY_W-1:0] key,
                            output outcome_t predicted);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, key};
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        predicted = apply_table_op(kind, key);
    endtask

    // Writes table_size once the block has drained, then reads it back.
    task automatic set_table_size(input logic [CFG_SIZE_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_TABLE_SIZE, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        shadow_size = value;
        // Go straight into the read setup phase; psel stays high.
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata != APB_DATA_W'(value))
            report_mismatch($sformatf("table_size readback %0d, wrote %0d", prdata, value));
        psel    <= 1'b0;
        penable <= 1'b0;
        // Leave the bus idle before anything else is driven.
        @(posedge aclk);
    endtask

    // Result side: random stalls, then check each word against the oldest expectation.
    initial begin
        int       gap;
        outcome_t got;
        outcome_t want;
        do @(posedge aclk); while (!aresetn);
        forever begin
            gap = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got = outcome_t'(m_tdata[M_FIELDS_W-1:0]);
            if (pending_outcomes.size() == 0) begin
                report_mismatch($sformatf("unexpected word, status %0d slot %0d",
                                          got.status, got.slot));
            end else begin
                want = pending_outcomes.pop_front();
                if (got.status != want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              got.status, want.status));
                if (got.slot != want.slot)
                    report_mismatch($sformatf("slot_index %0d, expected %0d",
                                              got.slot, want.slot));
                if (got.probes != want.probes)
                    report_mismatch($sformatf("probe_count %0d, expected %0d",
                                              got.probes, want.probes));
                if (got.occupied != want.occupied)
                    report_mismatch($sformatf("occupied_count %0d, expected %0d",
                                              got.occupied, want.occupied));
            end
            words_seen++;
        end
    end

    // Stimulus: reset, directed table, then random phases at varying table sizes.
    initial begin
        outcome_t              predicted;
        logic                  kind;
        logic [KEY_W-1:0]      key;
        logic [CFG_SIZE_W-1:0] new_size;
        int                    issued;
        int                    phase_len;
        int                    insert_share;
        int                    pick;

        foreach (shadow_slots[i]) shadow_slots[i] = '0;
        shadow_filled = 0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_steps[i]) begin
            if (directed_steps[i].op == ROW_SIZE) begin
                set_table_size(directed_steps[i].arg[CFG_SIZE_W-1:0]);
            end else begin
                kind = (directed_steps[i].op == ROW_SEARCH) ? KIND_SEARCH : KIND_INSERT;
                issue_op(kind, directed_steps[i].arg, predicted);
                pending_outcomes.push_back(directed_steps[i].typed ?
                                           directed_steps[i].want : predicted);
                if (predicted.status == ST_INSERTED)
                    stored_keys.push_back(directed_steps[i].arg);
            end
        end

        issued = 0;
        while (issued < RANDOM_ITEMS) begin
            // Mostly small tables so that full scans stay short.
            pick = $urandom_range(0, 9);
            case (pick)
                0: new_size = '0;
                1: new_size = 11'd1;
                2: new_size = 11'd2047;
                3: new_size = 11'd1024;
                4: new_size = CFG_SIZE_W'($urandom_range(65, 2047));
                default: new_size = CFG_SIZE_W'($urandom_range(2, 64));
            endcase
            set_table_size(new_size);
            calm = ($urandom_range(0, 3) == 0);
            insert_share = (new_size > 64) ? 20 : 50;
            phase_len = $urandom_range(30, 90);

            repeat (phase_len) begin
                pick = $urandom_range(0, 99);
                if (pick < 3) begin
                    kind = ($urandom_range(0, 1) == 0) ? KIND_INSERT : KIND_SEARCH;
                    key  = '0;
                end else begin
                    kind = (pick < 3 + insert_share) ? KIND_INSERT : KIND_SEARCH;
                    if (stored_keys.size() != 0 && $urandom_range(0, 99) <
                        ((kind == KIND_INSERT) ? 30 : 50)) begin
                        key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
                    end else if ($urandom_range(0, 3) == 0) begin
                        key = KEY_W'($urandom_range(1, 300));
                    end else begin
                        key = KEY_W'($urandom);
                    end
                end
                issue_op(kind, key, predicted);
                pending_outcomes.push_back(predicted);
                if (predicted.status == ST_INSERTED)
                    stored_keys.push_back(key);
                issued++;
            end
        end

        s_tvalid <= 1'b0;
        calm = 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: linear_probing_hash_table.f
design/lpht_pkg.sv
design/lpht_datapath.sv
design/lpht_ctrl.sv
design/linear_probing_hash_table.sv
design/lpht_checker.sv
tb/tb_linear_probing_hash_table.sv
